### rtl/ofp_pkg.sv
// ----------------------------------------------------------------------------
// ofp_pkg
// Shared widths, opcode codes, fixed payload lengths and the command and
// status words between the frame parser's controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ofp_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;
  localparam int FLEN_W = 6;
  localparam int LEN_W  = 10;

  localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hAA;
  localparam logic [BYTE_W-1:0] OPC_TOPOLOGY = 8'hE4;
  localparam logic [LEN_W-1:0]  TOPO_HEADER  = 10'd3;

  localparam logic [BYTE_W-1:0] OPC_E5 = 8'hE5;
  localparam logic [BYTE_W-1:0] OPC_E6 = 8'hE6;
  localparam logic [BYTE_W-1:0] OPC_E7 = 8'hE7;
  localparam logic [BYTE_W-1:0] OPC_E8 = 8'hE8;
  localparam logic [BYTE_W-1:0] OPC_E9 = 8'hE9;
  localparam logic [BYTE_W-1:0] OPC_EA = 8'hEA;
  localparam logic [BYTE_W-1:0] OPC_F0 = 8'hF0;
  localparam logic [BYTE_W-1:0] OPC_F1 = 8'hF1;
  localparam logic [BYTE_W-1:0] OPC_F2 = 8'hF2;
  localparam logic [BYTE_W-1:0] OPC_F4 = 8'hF4;
  localparam logic [BYTE_W-1:0] OPC_F5 = 8'hF5;

  typedef struct packed {
    logic take_opcode;
    logic take_payload;
    logic load_marker;
    logic start_emit;
    logic emit_load;
  } ofp_cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic zero_len;
    logic oversize;
    logic complete;
    logic out_free;
    logic emit_last;
  } ofp_stat_t;

  function automatic logic [2:0] fixed_length(input logic [BYTE_W-1:0] op);
    logic [2:0] len;
    case (op)
      OPC_E5, OPC_E6, OPC_E7, OPC_E8, OPC_E9, OPC_EA, OPC_F2, OPC_F5: len = 3'd1;
      OPC_F0:  len = 3'd2;
      OPC_F1:  len = 3'd7;
      OPC_F4:  len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/ofp_ram.sv
// ----------------------------------------------------------------------------
// ofp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ofp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/ofp_ctrl.sv
// ----------------------------------------------------------------------------
// ofp_ctrl
// Frame parser controller: hunt, opcode and payload phases, then a read
// priming step and the emission of the buffered payload words.
// ----------------------------------------------------------------------------
`default_nettype none

module ofp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ofp_pkg::ofp_stat_t stat,
  output ofp_pkg::ofp_cmd_t      cmd
);

  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_OPCODE  = 3'd1;
  localparam logic [2:0] ST_PAYLOAD = 3'd2;
  localparam logic [2:0] ST_PRIME   = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       receiving;
  logic       accept;

  assign receiving = (state_r == ST_HUNT) || (state_r == ST_OPCODE) ||
                     (state_r == ST_PAYLOAD);
  assign in_stall  = !receiving || !stat.out_free;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_HUNT: begin
        if (accept && stat.sync_hit) begin
          state_nxt = ST_OPCODE;
        end
      end
      ST_OPCODE: begin
        if (accept) begin
          cmd.take_opcode = 1'b1;
          if (stat.zero_len) begin
            cmd.load_marker = 1'b1;
            state_nxt       = ST_HUNT;
          end else begin
            state_nxt = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        if (accept) begin
          cmd.take_payload = 1'b1;
          if (stat.oversize) begin
            cmd.load_marker = 1'b1;
            state_nxt       = ST_HUNT;
          end else if (stat.complete) begin
            cmd.start_emit = 1'b1;
            state_nxt      = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) begin
            state_nxt = ST_HUNT;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/ofp_dp.sv
// ----------------------------------------------------------------------------
// ofp_dp
// Frame parser datapath: sync register, opcode and length tracking, payload
// buffer, emission index and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module ofp_dp #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [ofp_pkg::BYTE_W-1:0]  cfg_wr_data,
  input  wire logic [ofp_pkg::BYTE_W-1:0]  in_rx_byte,
  input  wire ofp_pkg::ofp_cmd_t           cmd,
  output ofp_pkg::ofp_stat_t               stat,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ofp_pkg::BYTE_W-1:0]       out_frame_opcode,
  output logic [ofp_pkg::IDX_W-1:0]        out_byte_index,
  output logic [ofp_pkg::BYTE_W-1:0]       out_data_byte,
  output logic [ofp_pkg::FLEN_W-1:0]       out_frame_len,
  output logic                             out_has_data,
  output logic                             out_oversize,
  output logic                             out_last
);

  localparam int AW     = $clog2(MAX_PAYLOAD);
  localparam int FILL_W = $clog2(MAX_PAYLOAD + 1);
  localparam int LEN_W  = ofp_pkg::LEN_W;
  localparam int BYTE_W = ofp_pkg::BYTE_W;

  logic [BYTE_W-1:0] sync_r;
  logic [BYTE_W-1:0] held_r;
  logic [FILL_W-1:0] fill_r;
  logic [LEN_W-1:0]  need_r;
  logic [BYTE_W-1:0] hdr1_r;
  logic [AW-1:0]     idx_r;

  logic                      out_valid_r;
  logic [BYTE_W-1:0]         out_op_r;
  logic [ofp_pkg::IDX_W-1:0] out_idx_r;
  logic [BYTE_W-1:0]         out_data_r;
  logic [ofp_pkg::FLEN_W-1:0] out_len_r;
  logic                      out_has_r;
  logic                      out_over_r;
  logic                      out_last_r;

  logic [FILL_W-1:0] fill_inc;
  logic              topo_hdr;
  logic [LEN_W-1:0]  topo_len;
  logic [LEN_W-1:0]  need_eff;
  logic [LEN_W-1:0]  opc_len;
  logic [AW-1:0]     idx_inc;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign fill_inc = fill_r + FILL_W'(1);
  assign topo_hdr = (held_r == ofp_pkg::OPC_TOPOLOGY) &&
                    (LEN_W'(fill_inc) == ofp_pkg::TOPO_HEADER);
  assign topo_len = ofp_pkg::TOPO_HEADER + LEN_W'(hdr1_r) + LEN_W'(in_rx_byte);
  assign need_eff = topo_hdr ? topo_len : need_r;
  assign opc_len  = (in_rx_byte == ofp_pkg::OPC_TOPOLOGY) ? ofp_pkg::TOPO_HEADER :
                    LEN_W'(ofp_pkg::fixed_length(in_rx_byte));
  assign idx_inc  = idx_r + AW'(1);
  assign rd_addr  = cmd.emit_load ? idx_inc : idx_r;

  always_comb begin
    stat.sync_hit  = (in_rx_byte == sync_r);
    stat.zero_len  = (opc_len == '0);
    stat.oversize  = topo_hdr && (topo_len > LEN_W'(MAX_PAYLOAD));
    stat.complete  = (LEN_W'(fill_inc) >= need_eff);
    stat.out_free  = !out_valid_r || !out_stall;
    stat.emit_last = ((LEN_W'(idx_r) + LEN_W'(1)) == need_r);
  end

  ofp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.take_payload),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= ofp_pkg::SYNC_RESET;
    end else if (cfg_wr_en) begin
      sync_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      fill_r <= '0;
      need_r <= '0;
    end else if (cmd.take_opcode) begin
      held_r <= in_rx_byte;
      fill_r <= '0;
      need_r <= opc_len;
    end else if (cmd.take_payload) begin
      fill_r <= fill_inc;
      need_r <= need_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_payload && (fill_r == FILL_W'(1))) begin
      hdr1_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.start_emit) begin
      idx_r <= '0;
    end else if (cmd.emit_load) begin
      idx_r <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_marker || cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_marker) begin
      out_op_r   <= cmd.take_opcode ? in_rx_byte : held_r;
      out_idx_r  <= '0;
      out_data_r <= '0;
      out_len_r  <= '0;
      out_has_r  <= 1'b0;
      out_over_r <= cmd.take_payload;
      out_last_r <= 1'b1;
    end else if (cmd.emit_load) begin
      out_op_r   <= held_r;
      out_idx_r  <= ofp_pkg::IDX_W'(LEN_W'(idx_r));
      out_data_r <= rd_data;
      out_len_r  <= need_r[ofp_pkg::FLEN_W-1:0];
      out_has_r  <= 1'b1;
      out_over_r <= 1'b0;
      out_last_r <= stat.emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_opcode = out_op_r;
  assign out_byte_index   = out_idx_r;
  assign out_data_byte    = out_data_r;
  assign out_frame_len    = out_len_r;
  assign out_has_data     = out_has_r;
  assign out_oversize     = out_over_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

### rtl/opcode_length_frame_parser.sv
// ----------------------------------------------------------------------------
// opcode_length_frame_parser
// Sync, opcode and length framed byte parser with a buffered payload.
//
// Bytes enter on the in_ channel (in_valid, in_stall, in_rx_byte) and
// result words leave on the out_ channel, one word per payload byte with
// out_last on the final one. Frames with no payload, and dropped oversize
// topology frames, give a single word with out_has_data low.
// cfg_wr_en with cfg_wr_data sets the sync byte; write it only while idle.
// A byte is taken every cycle while the parser hunts, reads the opcode or
// fills the buffer and the output register is free. A marker word appears
// in the cycle after its byte is taken. When a frame completes, the parser
// first primes the buffer read port, then one word per cycle follows while
// out_stall is low; in_stall stays high through priming and emission.
// The buffer read port sets that rate. While out_stall holds a word, the
// output register keeps it, emission pauses and in_stall stays high.
// Reset returns the parser to hunting, empties the output register and
// loads the sync byte with 0xAA; the buffer needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module opcode_length_frame_parser #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [ofp_pkg::BYTE_W-1:0]  cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [ofp_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ofp_pkg::BYTE_W-1:0]       out_frame_opcode,
  output logic [ofp_pkg::IDX_W-1:0]        out_byte_index,
  output logic [ofp_pkg::BYTE_W-1:0]       out_data_byte,
  output logic [ofp_pkg::FLEN_W-1:0]       out_frame_len,
  output logic                             out_has_data,
  output logic                             out_oversize,
  output logic                             out_last
);

  ofp_pkg::ofp_cmd_t  cmd;
  ofp_pkg::ofp_stat_t stat;

  ofp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ofp_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_opcode (out_frame_opcode),
    .out_byte_index   (out_byte_index),
    .out_data_byte    (out_data_byte),
    .out_frame_len    (out_frame_len),
    .out_has_data     (out_has_data),
    .out_oversize     (out_oversize),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the sync/opcode/length frame parser. Serial bytes are fed
// through the valid/stall input channel and every result word is compared
// field by field against a cycle-free model of the parser kept here. The
// run covers the opcode set, zero-length and topology frames, the buffer
// boundary and oversize drops, under several sync byte settings, with random
// idle and stall cycles on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAYLOAD = 32;
  localparam int LIMIT       = 200000;
  localparam int PER_SETTING = 52;
  localparam logic [ofp_pkg::BYTE_W-1:0] OPC_PING = 8'hF3;

  typedef enum logic [1:0] {HUNT, OPCODE, FILL} phase_t;

  typedef struct packed {
    logic [ofp_pkg::BYTE_W-1:0] opcode;
    logic [ofp_pkg::IDX_W-1:0]  idx;
    logic [ofp_pkg::BYTE_W-1:0] data;
    logic [ofp_pkg::FLEN_W-1:0] flen;
    logic                       has;
    logic                       over;
    logic                       last;
  } word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [ofp_pkg::BYTE_W-1:0] cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [ofp_pkg::BYTE_W-1:0] in_rx_byte = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ofp_pkg::BYTE_W-1:0] out_frame_opcode;
  logic [ofp_pkg::IDX_W-1:0]  out_byte_index;
  logic [ofp_pkg::BYTE_W-1:0] out_data_byte;
  logic [ofp_pkg::FLEN_W-1:0] out_frame_len;
  logic                       out_has_data;
  logic                       out_oversize;
  logic                       out_last;

  opcode_length_frame_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_opcode (out_frame_opcode),
    .out_byte_index   (out_byte_index),
    .out_data_byte    (out_data_byte),
    .out_frame_len    (out_frame_len),
    .out_has_data     (out_has_data),
    .out_oversize     (out_oversize),
    .out_last         (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser model state
  logic [ofp_pkg::BYTE_W-1:0] sync_now = ofp_pkg::SYNC_RESET;
  phase_t                     phase_now = HUNT;
  logic [ofp_pkg::BYTE_W-1:0] op_held = '0;
  int                         filled = 0;
  int                         need = 0;
  logic [ofp_pkg::BYTE_W-1:0] frame_buf [MAX_PAYLOAD];

  logic [ofp_pkg::BYTE_W-1:0] byte_q [$];
  word_t                      frame_word_q [$];
  int                         n_queued = 0;
  int                         n_noise = 0;
  int                         n_taken = 0;
  logic                       in_took = 1'b0;
  logic                       failed = 1'b0;
  int                         cyc = 0;
  logic                       calm;

  assign calm = (n_taken >= 220) && (n_taken < 300);

  function automatic int payload_len(input logic [ofp_pkg::BYTE_W-1:0] op);
    case (op)
      ofp_pkg::OPC_E5, ofp_pkg::OPC_E6, ofp_pkg::OPC_E7, ofp_pkg::OPC_E8,
      ofp_pkg::OPC_E9, ofp_pkg::OPC_EA, ofp_pkg::OPC_F2, ofp_pkg::OPC_F5: return 1;
      ofp_pkg::OPC_F0: return 2;
      ofp_pkg::OPC_F1: return 7;
      ofp_pkg::OPC_F4: return 4;
      default:         return 0;
    endcase
  endfunction

  function automatic word_t mk_word(input logic [ofp_pkg::BYTE_W-1:0] op, input int idx,
                                    input logic [ofp_pkg::BYTE_W-1:0] data,
                                    input int flen, input logic has, input logic over,
                                    input logic last);
    word_t w;
    w.opcode = op;
    w.idx    = idx[ofp_pkg::IDX_W-1:0];
    w.data   = data;
    w.flen   = flen[ofp_pkg::FLEN_W-1:0];
    w.has    = has;
    w.over   = over;
    w.last   = last;
    return w;
  endfunction

  task automatic parse_byte(input logic [ofp_pkg::BYTE_W-1:0] b);
    case (phase_now)
      HUNT: begin
        if (b == sync_now) phase_now = OPCODE;
      end
      OPCODE: begin
        op_held = b;
        filled  = 0;
        need    = (b == ofp_pkg::OPC_TOPOLOGY) ? int'(ofp_pkg::TOPO_HEADER) :
                  payload_len(b);
        if (need == 0) begin
          frame_word_q.push_back(mk_word(b, 0, '0, 0, 1'b0, 1'b0, 1'b1));
          phase_now = HUNT;
        end else begin
          phase_now = FILL;
        end
      end
      default: begin
        if (filled < MAX_PAYLOAD) frame_buf[filled] = b;
        filled++;
        if (op_held == ofp_pkg::OPC_TOPOLOGY && filled == int'(ofp_pkg::TOPO_HEADER)) begin
          need = int'(ofp_pkg::TOPO_HEADER) + frame_buf[1] + frame_buf[2];
          if (need > MAX_PAYLOAD) begin
            frame_word_q.push_back(mk_word(op_held, 0, '0, 0, 1'b0, 1'b1, 1'b1));
            phase_now = HUNT;
            return;
          end
        end
        if (filled >= need) begin
          for (int i = 0; i < need; i++)
            frame_word_q.push_back(mk_word(op_held, i, frame_buf[i], need, 1'b1, 1'b0,
                                           i + 1 == need));
          phase_now = HUNT;
        end
      end
    endcase
  endtask

  task automatic report(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    failed = 1'b1;
  endtask

  task automatic check_word(input word_t w);
    if (out_frame_opcode !== w.opcode) report("frame_opcode", w.opcode, out_frame_opcode);
    if (out_byte_index !== w.idx)      report("byte_index", w.idx, out_byte_index);
    if (out_data_byte !== w.data)      report("data_byte", w.data, out_data_byte);
    if (out_frame_len !== w.flen)      report("frame_len", w.flen, out_frame_len);
    if (out_has_data !== w.has)        report("has_data", w.has, out_has_data);
    if (out_oversize !== w.over)       report("oversize", w.over, out_oversize);
    if (out_last !== w.last)           report("last", w.last, out_last);
  endtask

  // check results first, then account for the byte taken at this edge
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("tb failed");
      $finish;
    end else if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (frame_word_q.size() == 0) begin
          $display("%0t: unexpected word, opcode %0h index %0d data %0h", $time,
                   out_frame_opcode, out_byte_index, out_data_byte);
          failed = 1'b1;
        end else begin
          check_word(frame_word_q.pop_front());
        end
      end
      in_took <= in_valid && (in_stall === 1'b0);
      if (in_valid && in_stall === 1'b0) begin
        parse_byte(in_rx_byte);
        n_taken <= n_taken + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
        in_valid   <= 1'b1;
        in_rx_byte <= byte_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !calm && ($urandom_range(99) < 19);
  end

  task automatic send(input logic [ofp_pkg::BYTE_W-1:0] b);
    byte_q.push_back(b);
    n_queued++;
  endtask

  // hold until idle: finish any open frame, drain results, let the pipe empty
  task automatic settle();
    while (n_taken != n_queued) @(negedge clk);
    while (phase_now != HUNT) begin
      send('0);
      while (n_taken != n_queued) @(negedge clk);
    end
    while (frame_word_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_sync(input logic [ofp_pkg::BYTE_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    sync_now    = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [ofp_pkg::BYTE_W-1:0] pick_op();
    int k;
    k = $urandom_range(99);
    if (k < 25) return ofp_pkg::OPC_TOPOLOGY;
    if (k < 80) begin
      case ($urandom_range(11))
        0:  return ofp_pkg::OPC_E5;
        1:  return ofp_pkg::OPC_E6;
        2:  return ofp_pkg::OPC_E7;
        3:  return ofp_pkg::OPC_E8;
        4:  return ofp_pkg::OPC_E9;
        5:  return ofp_pkg::OPC_EA;
        6:  return ofp_pkg::OPC_F0;
        7:  return ofp_pkg::OPC_F1;
        8:  return ofp_pkg::OPC_F2;
        9:  return ofp_pkg::OPC_F4;
        10: return ofp_pkg::OPC_F5;
        default: return OPC_PING;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_frame();
    logic [ofp_pkg::BYTE_W-1:0] op;
    int extra;
    int b1;
    int lo;
    int hi;
    int s;
    op = pick_op();
    send(sync_now);
    send(op);
    if (op == ofp_pkg::OPC_TOPOLOGY) begin
      s = $urandom_range(9);
      if (s == 0)      extra = MAX_PAYLOAD - int'(ofp_pkg::TOPO_HEADER);
      else if (s == 1) extra = MAX_PAYLOAD - int'(ofp_pkg::TOPO_HEADER) + 1;
      else if (s == 2) extra = 30 + $urandom_range(480);
      else             extra = $urandom_range(12);
      lo = (extra > 255) ? extra - 255 : 0;
      hi = (extra < 255) ? extra : 255;
      b1 = $urandom_range(hi, lo);
      send(8'($urandom_range(255)));
      send(8'(b1));
      send(8'(extra - b1));
      if (extra + int'(ofp_pkg::TOPO_HEADER) <= MAX_PAYLOAD)
        repeat (extra) send(8'($urandom_range(255)));
    end else begin
      repeat (payload_len(op)) send(8'($urandom_range(255)));
    end
  endtask

  task automatic random_bytes(input int quota);
    int base;
    int r;
    base = n_queued - n_noise;
    while (n_queued - n_noise - base < quota) begin
      r = $urandom_range(99);
      if (r < 10) begin
        repeat ($urandom_range(3, 1)) begin
          send(8'($urandom_range(255)));
          n_noise++;
        end
      end else if (r < 18) begin
        send(sync_now);
        send(pick_op());
        repeat ($urandom_range(3)) send(8'($urandom_range(255)));
      end else begin
        send_frame();
      end
    end
  endtask

  initial begin
    logic [ofp_pkg::BYTE_W-1:0] directed [];
    directed = '{
      8'h00, 8'hFF,
      ofp_pkg::SYNC_RESET, OPC_PING,
      ofp_pkg::SYNC_RESET, ofp_pkg::OPC_E5, 8'hFF,
      ofp_pkg::SYNC_RESET, ofp_pkg::OPC_F1,
      8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'hFF,
      ofp_pkg::SYNC_RESET, ofp_pkg::OPC_TOPOLOGY, 8'h00, 8'h00, 8'h00,
      ofp_pkg::SYNC_RESET, ofp_pkg::OPC_TOPOLOGY, 8'h5A, 8'hFF, 8'h00
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send(directed[i]);
    random_bytes(PER_SETTING);
    settle();
    set_sync(8'h00);
    random_bytes(PER_SETTING);
    settle();
    set_sync(8'hFF);
    random_bytes(PER_SETTING);
    settle();
    set_sync(8'($urandom_range(255)));
    random_bytes(PER_SETTING);
    settle();
    set_sync(ofp_pkg::OPC_TOPOLOGY);
    random_bytes(PER_SETTING);
    settle();
    set_sync(ofp_pkg::SYNC_RESET);
    random_bytes(PER_SETTING);
    settle();

    repeat (40) @(posedge clk);
    if (frame_word_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, frame_word_q.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
